FILE: hw/rtl/wgm_pkg.sv
// Shared constants, types and helpers of the wildcard glob matcher.
package wgm_pkg;

	localparam int MaxPattern = 64;
	localparam int LenW       = $clog2(MaxPattern + 1);
	localparam int IdxW       = $clog2(MaxPattern);
	localparam int Levels     = $clog2(MaxPattern + 1);

	localparam logic [7:0] StarByte  = 8'h2A;
	localparam logic [7:0] QmarkByte = 8'h3F;
	localparam logic [7:0] LowerA    = 8'h61;
	localparam logic [7:0] LowerZ    = 8'h7A;
	localparam logic [7:0] CaseDelta = 8'h20;

	localparam logic [2:0] RegCaseSensitive = 3'h0;

	typedef enum logic [1:0] {
		ModeClear   = 2'd0,
		ModeAppend  = 2'd1,
		ModeSubject = 2'd2,
		ModeEnd     = 2'd3
	} mode_t;

	typedef logic [MaxPattern:0]   pos_vec_t;
	typedef logic [MaxPattern-1:0] star_vec_t;

	function automatic logic [7:0] fold(input logic [7:0] b, input logic case_sensitive);
		logic [7:0] r;
		r = b;
		if (!case_sensitive && b >= LowerA && b <= LowerZ) begin
			r = b - CaseDelta;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/wgm_if.sv
// Valid/ready channel interfaces for input items and match results.
interface wgm_item_if;
	import wgm_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] char_byte;

	modport source (output valid, output mode, output char_byte, input ready);
	modport sink (input valid, input mode, input char_byte, output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

FILE: hw/rtl/wgm_closure.sv
// Star closure of an active-position set, as a log-depth prefix network.
module wgm_closure (
	input  wgm_pkg::pos_vec_t  set,
	input  wgm_pkg::star_vec_t star,
	output wgm_pkg::pos_vec_t  closed
);
	import wgm_pkg::*;

	logic [Levels:0][MaxPattern:0] g;
	logic [Levels:0][MaxPattern:0] p;

	assign g[0] = set;
	assign p[0] = {star, 1'b0};

	for (genvar l = 0; l < Levels; l++) begin : g_level
		for (genvar i = 0; i <= MaxPattern; i++) begin : g_pos
			if (i >= (1 << l)) begin : g_merge
				assign g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1<<l)]);
				assign p[l+1][i] = p[l][i] & p[l][i-(1<<l)];
			end else begin : g_pass
				assign g[l+1][i] = g[l][i];
				assign p[l+1][i] = p[l][i];
			end
		end
	end

	assign closed = g[Levels];

endmodule

FILE: hw/rtl/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: input stage, pattern store, active set, result register.
//
// Whole-string matcher for patterns with '*' (any run of bytes) and '?' (any one byte).
// Mode 0 clears the pattern, mode 1 appends a pattern byte, mode 2 feeds a subject byte and
// mode 3 ends the subject and returns one result word; appending or clearing restarts any
// subject in progress. One word is accepted every cycle unless an end-of-subject word stalls
// in the input stage while the result register holds an untaken result. The per-cycle limit is
// the active-set update: star closure through a seven-level prefix network, then one compare per
// pattern position. A pattern of more than 64 bytes sets pattern_overflow and forces a miss.
// Register 0 at address 0, bit 0: case_sensitive (0 folds ASCII letters to upper case).
module wildcard_glob_matcher_top (
	input  logic         clk,
	input  logic         arst_n,
	wgm_item_if.sink     item,
	wgm_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import wgm_pkg::*;

	logic              cs_q;
	logic              valid_s1;
	mode_t             mode_s1;
	logic [7:0]        char_s1;
	logic [7:0]        store_q [MaxPattern];
	logic [LenW-1:0]   len_q;
	logic              ovf_q;
	pos_vec_t          active_q;
	logic              out_valid_q;
	logic              matched_q;
	logic              out_ovf_q;

	logic              adv_s1;
	logic              fire_s1;
	logic              room;
	logic [7:0]        c_fold;
	star_vec_t         star;
	star_vec_t         hit;
	pos_vec_t          cur;
	pos_vec_t          nxt;
	pos_vec_t          rearm;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'(4 * RegCaseSensitive)) ? {31'b0, cs_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == RegCaseSensitive[0]) begin
			cs_q <= pwdata[0];
		end
	end

	assign adv_s1      = (mode_s1 != ModeEnd) || !out_valid_q || result.ready;
	assign fire_s1     = valid_s1 && adv_s1;
	assign item.ready  = !valid_s1 || adv_s1;
	assign room        = len_q < LenW'(MaxPattern);
	assign c_fold      = fold(char_s1, cs_q);
	assign rearm       = pos_vec_t'(1);

	always_comb begin
		for (int i = 0; i < MaxPattern; i++) begin
			star[i] = (store_q[i] == StarByte) && (LenW'(i) < len_q);
			hit[i]  = (LenW'(i) < len_q) && (store_q[i] != StarByte)
			          && (store_q[i] == QmarkByte || fold(store_q[i], cs_q) == c_fold);
		end
	end

	wgm_closure u_closure (
		.set    (active_q),
		.star   (star),
		.closed (cur)
	);

	assign nxt = ({1'b0, star} & cur) | ({hit, 1'b0} & (cur << 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			mode_s1 <= mode_t'(item.mode);
			char_s1 <= item.char_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && mode_s1 == ModeAppend && room) begin
			store_q[len_q[IdxW-1:0]] <= char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			active_q <= pos_vec_t'(1);
		end else if (fire_s1) begin
			case (mode_s1)
				ModeClear: begin
					len_q    <= '0;
					ovf_q    <= 1'b0;
					active_q <= rearm;
				end
				ModeAppend: begin
					if (room) begin
						len_q <= len_q + LenW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					active_q <= rearm;
				end
				ModeSubject: begin
					active_q <= nxt;
				end
				default: begin
					active_q <= rearm;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && mode_s1 == ModeEnd) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && mode_s1 == ModeEnd) begin
			matched_q <= cur[len_q] && !ovf_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_overflow = out_ovf_q;

endmodule

FILE: test/wildcard_glob_matcher_top_tb.sv
// Self-checking testbench of the wildcard glob matcher: shadow automaton, random traffic, APB.
module wildcard_glob_matcher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wgm_pkg::*;

	localparam int CycleLimit  = 300000;
	localparam int PhaseWords  = 210;
	localparam int Phases      = 5;
	localparam int SettleDelay = 6;

	class glob_match_model;
		typedef struct packed {
			logic matched;
			logic overflow;
		} verdict_t;

		logic       case_exact;
		logic [7:0] pat_bytes [MaxPattern];
		int         pat_len;
		logic       pat_overflow;
		pos_vec_t   live;
		verdict_t   due [$];
		int         errors;
		int         words;
		int         checked;
		int         hits;
		int         overflows;

		function new();
			case_exact   = 1'b0;
			pat_len      = 0;
			pat_overflow = 1'b0;
			errors       = 0;
			words        = 0;
			checked      = 0;
			hits         = 0;
			overflows    = 0;
			rearm();
		endfunction

		function void rearm();
			live    = '0;
			live[0] = 1'b1;
		endfunction

		function logic [7:0] upper(logic [7:0] b);
			if (!case_exact && b >= LowerA && b <= LowerZ) begin
				return b - CaseDelta;
			end
			return b;
		endfunction

		// a live star also makes the position after it live
		function pos_vec_t close_stars(pos_vec_t s);
			for (int p = 0; p < pat_len; p++) begin
				if (s[p] && pat_bytes[p] == StarByte) begin
					s[p + 1] = 1'b1;
				end
			end
			return s;
		endfunction

		function void take_word(mode_t m, logic [7:0] b);
			pos_vec_t   cur;
			pos_vec_t   nxt;
			logic [7:0] c;
			verdict_t   v;
			words++;
			case (m)
				ModeClear: begin
					pat_len      = 0;
					pat_overflow = 1'b0;
					rearm();
				end
				ModeAppend: begin
					if (pat_len < MaxPattern) begin
						pat_bytes[pat_len] = b;
						pat_len++;
					end else begin
						pat_overflow = 1'b1;
					end
					rearm();
				end
				ModeSubject: begin
					c   = upper(b);
					cur = close_stars(live);
					nxt = '0;
					for (int p = 0; p < pat_len; p++) begin
						if (cur[p]) begin
							if (pat_bytes[p] == StarByte) begin
								nxt[p] = 1'b1;
							end else if (pat_bytes[p] == QmarkByte || upper(pat_bytes[p]) == c) begin
								nxt[p + 1] = 1'b1;
							end
						end
					end
					live = nxt;
				end
				default: begin
					cur        = close_stars(live);
					v.matched  = cur[pat_len] && !pat_overflow;
					v.overflow = pat_overflow;
					due.push_back(v);
					rearm();
				end
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_verdict(logic m, logic o);
			verdict_t want;
			if (due.size() == 0) begin
				report($sformatf("result word matched=%0b overflow=%0b with none pending", m, o));
				return;
			end
			want = due.pop_front();
			checked++;
			hits      += want.matched;
			overflows += want.overflow;
			if (m !== want.matched) begin
				report($sformatf("result %0d: matched=%0b, want %0b", checked, m, want.matched));
			end
			if (o !== want.overflow) begin
				report($sformatf("result %0d: pattern_overflow=%0b, want %0b", checked, o,
					want.overflow));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wgm_item_if   item_ch ();
	wgm_result_if result_ch ();

	glob_match_model glob;
	logic [7:0]      pat_q [$];
	bit              calm;
	int              sent;
	int              writes;
	int              cycles;

	wildcard_glob_matcher_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("wildcard_glob_matcher_top_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			glob.take_word(mode_t'(item_ch.mode), item_ch.char_byte);
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			glob.check_verdict(result_ch.matched, result_ch.pattern_overflow);
		end
	end

	function automatic int idle_cycles();
		if (calm || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return int'($urandom_range(0, 17));
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return 8'h61 + 8'($urandom_range(0, 2));
			end
			3, 4: begin
				return 8'h41 + 8'($urandom_range(0, 2));
			end
			5: begin
				return StarByte;
			end
			6: begin
				return QmarkByte;
			end
			7: begin
				return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				return any_byte();
			end
		endcase
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] b);
		if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
			return b ^ CaseDelta;
		end
		return b;
	endfunction

	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	task automatic send(mode_t m, logic [7:0] b);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.mode      <= m;
		item_ch.char_byte <= b;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
	endtask

	// drop valid, drain pending results, let the pipeline empty
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (glob.due.size() != 0) @(posedge clk);
		repeat (SettleDelay) @(posedge clk);
	endtask

	task automatic write_case_mode(logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * RegCaseSensitive);
		pwdata  <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		glob.case_exact = value;
		writes++;
	endtask

	task automatic run_round(bit long_pat);
		int         plen;
		int         nsubj;
		int         pos;
		int         k;
		logic [7:0] subj [$];
		logic [7:0] b;
		calm = ($urandom_range(0, 4) == 0);
		if (long_pat) begin
			plen = $urandom_range(63, 70);
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					plen = $urandom_range(60, 68);
				end
				1, 2, 3: begin
					plen = $urandom_range(8, 24);
				end
				default: begin
					plen = $urandom_range(0, 7);
				end
			endcase
		end
		if ($urandom_range(0, 5) != 0) begin
			pat_q.delete();
			send(ModeClear, any_byte());
		end
		repeat (plen) begin
			b = any_char();
			pat_q.push_back(b);
			send(ModeAppend, b);
		end
		nsubj = (plen > 24) ? 1 : $urandom_range(1, 4);
		repeat (nsubj) begin
			subj.delete();
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(0, 6)) subj.push_back(any_char());
			end else begin
				foreach (pat_q[i]) begin
					if (pat_q[i] == StarByte) begin
						repeat ($urandom_range(0, 3)) subj.push_back(any_char());
					end else if (pat_q[i] == QmarkByte) begin
						subj.push_back(any_char());
					end else begin
						subj.push_back($urandom_range(0, 2) == 0 ? flip_case(pat_q[i]) : pat_q[i]);
					end
				end
				if ($urandom_range(0, 3) == 0) begin
					pos = $urandom_range(0, subj.size());
					case ($urandom_range(0, 2))
						0: begin
							subj.insert(pos, any_char());
						end
						1: begin
							if (pos < subj.size()) subj.delete(pos);
						end
						default: begin
							if (pos < subj.size()) subj[pos] = any_char();
						end
					endcase
				end
			end
			foreach (subj[i]) begin
				k = $urandom_range(0, 59);
				if (k == 0) begin
					b = any_char();
					pat_q.push_back(b);
					send(ModeAppend, b);
				end else if (k == 1) begin
					pat_q.delete();
					send(ModeClear, any_byte());
				end
				send(ModeSubject, subj[i]);
			end
			if ($urandom_range(0, 29) == 0) begin
				send(ModeSubject, any_byte());
			end
			send(ModeEnd, any_byte());
		end
	endtask

	initial begin
		glob                = new();
		cycles              = 0;
		sent                = 0;
		writes              = 0;
		calm                = 1'b0;
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		item_ch.valid       <= 1'b0;
		item_ch.mode        <= ModeClear;
		item_ch.char_byte   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ModeEnd, any_byte());
		send(ModeAppend, StarByte);
		send(ModeEnd, any_byte());
		send(ModeClear, any_byte());
		send(ModeAppend, 8'h61);
		send(ModeAppend, QmarkByte);
		send(ModeAppend, 8'hFF);
		send(ModeSubject, 8'h41);
		send(ModeSubject, 8'h00);
		send(ModeSubject, 8'hFF);
		send(ModeEnd, any_byte());
		send(ModeSubject, 8'h5A);
		send(ModeAppend, 8'h00);
		send(ModeSubject, 8'h61);
		send(ModeSubject, StarByte);
		send(ModeSubject, 8'hFF);
		send(ModeSubject, 8'h00);
		send(ModeEnd, any_byte());
		send(ModeEnd, any_byte());
		send(ModeClear, any_byte());
		send(ModeAppend, 8'hE1);
		send(ModeSubject, 8'hC1);
		send(ModeEnd, any_byte());

		for (int phase = 0; phase < Phases; phase++) begin
			settle();
			write_case_mode(phase % 2 == 0);
			sent = 0;
			run_round(1'b1);
			while (sent < PhaseWords) run_round(1'b0);
		end
		settle();

		$display("covered %0d words and %0d results (%0d matches, %0d with overflow)",
			glob.words, glob.checked, glob.hits, glob.overflows);
		$display("%0d case mode writes, folding and exact compare alternating", writes);
		if (glob.errors == 0) begin
			$display("wildcard_glob_matcher_top_tb passed");
		end else begin
			$display("wildcard_glob_matcher_top_tb failed");
		end
		$finish;
	end

endmodule
